// ----- design/lsnd_pkg.sv -----
package lsnd_pkg;

  localparam int NUM_NOTES = 6;

  localparam int AMT_W  = 27;
  localparam int CNT_W  = 16;
  localparam int TOT_W  = 19;
  localparam int UNIT_W = 14;  // amount in units of the smallest note
  localparam int SEL_W  = 3;

  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // amount / 10000 == (amount * RECIP_BASE) >> BASE_SHIFT, exact for 27-bit amounts
  localparam logic [MUL_B_W-1:0] RECIP_BASE = 28'd219902326;
  localparam int                 BASE_SHIFT = 41;
  localparam logic [UNIT_W-1:0]  NOTE_BASE  = 14'd10000;

  // units / m == (units * NOTE_RECIP[k]) >> FIT_SHIFT, exact for 14-bit units
  localparam int FIT_SHIFT = 20;

  localparam logic [SEL_W-1:0] LAST_NOTE = 3'd5;

  // Note values in units of 10000
  localparam logic [5:0] NOTE_UNITS [NUM_NOTES] = '{
    6'd50, 6'd20, 6'd10, 6'd5, 6'd2, 6'd1
  };

  localparam logic [20:0] NOTE_RECIP [NUM_NOTES] = '{
    21'd20972, 21'd52429, 21'd104858, 21'd209716, 21'd524288, 21'd1048576
  };

  typedef struct packed {
    logic [AMT_W-1:0] amount;
    logic [SEL_W-1:0] start_denom;
    logic [CNT_W-1:0] stock_500k;
    logic [CNT_W-1:0] stock_200k;
    logic [CNT_W-1:0] stock_100k;
    logic [CNT_W-1:0] stock_50k;
    logic [CNT_W-1:0] stock_20k;
    logic [CNT_W-1:0] stock_10k;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] out_500k;
    logic [CNT_W-1:0] out_200k;
    logic [CNT_W-1:0] out_100k;
    logic [CNT_W-1:0] out_50k;
    logic [CNT_W-1:0] out_20k;
    logic [CNT_W-1:0] out_10k;
    logic [TOT_W-1:0] total_notes;
    logic             success;
  } rsp_t;

endpackage

// ----- design/limited_stock_note_dispenser.sv -----
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+-----------------------------------
// req     | in        | req_valid / req_ready | amount, start_denom, six stocks
// rsp     | out       | rsp_valid / rsp_ready | six note counts, total, success
//
// From acceptance until its result is registered, a transaction steps through DIV, BACK
// and REM to split the amount into units of 10000 and a residue, through FIT and TAKE for
// each allowed note kind with one shared registered multiplier, and through DONE to load the output register.
// req_ready is high only while the sequencer is idle; rst is synchronous, active high,
// and clears the sequencer and rsp_valid. A waiting result does not block the next
// accept; a finished transaction holds in its last step until the output is free.
module limited_stock_note_dispenser
  import lsnd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    IDLE,
    DIV,   // amount * reciprocal of 10000
    BACK,  // units back to currency, to find the residue
    REM,   // compare residue, pick first note kind
    FIT,   // units * reciprocal of note value
    TAKE,  // clamp to stock, reduce units
    DONE
  } state_t;

  state_t            state;
  req_t              item;
  logic [UNIT_W-1:0] units;
  logic              short_amt;
  logic [SEL_W-1:0]  k;
  logic [CNT_W-1:0]  cnt [NUM_NOTES];
  logic [TOT_W-1:0]  total;

  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic [UNIT_W-1:0] q_units;
  logic [UNIT_W-1:0] fit;
  logic [CNT_W-1:0]  stock_sel;
  logic [UNIT_W-1:0] take;
  logic [19:0]       take_units;
  logic [SEL_W-1:0]  first;

  assign req_ready = (state == IDLE);

  assign q_units = prod[PROD_W-1:BASE_SHIFT];
  assign fit     = prod[FIT_SHIFT+UNIT_W-1:FIT_SHIFT];

  // Start selector saturates at the smallest note
  assign first = (item.start_denom > LAST_NOTE) ? LAST_NOTE : item.start_denom;

  always_comb begin
    case (k)
      3'd0:    stock_sel = item.stock_500k;
      3'd1:    stock_sel = item.stock_200k;
      3'd2:    stock_sel = item.stock_100k;
      3'd3:    stock_sel = item.stock_50k;
      3'd4:    stock_sel = item.stock_20k;
      default: stock_sel = item.stock_10k;
    endcase
  end

  // Take what fits, but never more than the stock; stock below fit fits in UNIT_W
  assign take       = (CNT_W'(fit) < stock_sel) ? fit : stock_sel[UNIT_W-1:0];
  assign take_units = 20'(take) * 20'(NOTE_UNITS[k]);

  // Operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = item.amount;
    mul_b  = RECIP_BASE;
    unique case (state)
      DIV: begin
        mul_en = 1'b1;
      end
      BACK: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(q_units);
        mul_b  = MUL_B_W'(NOTE_BASE);
      end
      FIT: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(units);
        mul_b  = MUL_B_W'(NOTE_RECIP[k]);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  lsnd_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // Raise valid when a result loads, drop it once the consumer takes it
      if (state == DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (req_valid) begin
            item  <= req;
            total <= '0;
            for (int i = 0; i < NUM_NOTES; i++) begin
              cnt[i] <= '0;
            end
            state <= DIV;
          end
        end
        DIV: begin
          state <= BACK;
        end
        BACK: begin
          units <= q_units;
          state <= REM;
        end
        REM: begin
          // Anything below 10000 can never be paid out
          short_amt <= (prod[AMT_W-1:0] != item.amount);
          k         <= first;
          state     <= FIT;
        end
        FIT: begin
          state <= TAKE;
        end
        TAKE: begin
          cnt[k] <= CNT_W'(take);
          total  <= total + TOT_W'(take);
          units  <= units - take_units[UNIT_W-1:0];
          if (k == LAST_NOTE) begin
            state <= DONE;
          end else begin
            k     <= k + 3'd1;
            state <= FIT;
          end
        end
        DONE: begin
          // Hold until the output register is free
          if (!rsp_valid || rsp_ready) begin
            rsp.out_500k    <= cnt[0];
            rsp.out_200k    <= cnt[1];
            rsp.out_100k    <= cnt[2];
            rsp.out_50k     <= cnt[3];
            rsp.out_20k     <= cnt[4];
            rsp.out_10k     <= cnt[5];
            rsp.total_notes <= total;
            rsp.success     <= !short_amt && (units == '0);
            state           <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/lsnd_mul.sv -----
module lsnd_mul
  import lsnd_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [PROD_W-1:0]  prod
);

  // Registered product; hold when not enabled
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

// ----- tb/limited_stock_note_dispenser_tb.sv -----
module limited_stock_note_dispenser_tb;
  import lsnd_pkg::*;

  // Run length and stall shaping
  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT  = 600000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 24;      // more than the slowest transaction without stalls
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int HOLD_AT      = 40;      // results seen before the hold-off

  // Note values, largest first, in currency units
  localparam int unsigned NOTE_VALUE [NUM_NOTES] = '{
    500000, 200000, 100000, 50000, 20000, 10000
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  req_t pending_q [$];   // requests not yet offered to the block
  rsp_t payout_q [$];    // predicted payouts, oldest first

  int item_total = 0;
  int req_sent = 0;
  int rsp_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  limited_stock_note_dispenser DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #4 clk = ~clk;

  // Predict the payout: walk the notes from the largest allowed one down,
  // take as many as fit into what is left, but never more than stocked.
  function automatic rsp_t dispense_notes(req_t r);
    longint unsigned left;
    longint unsigned fit;
    longint unsigned take;
    longint unsigned total;
    int unsigned first;
    logic [CNT_W-1:0] stock [NUM_NOTES];
    logic [CNT_W-1:0] count [NUM_NOTES];
    rsp_t p;
    left  = r.amount;
    total = 0;
    // Saturate an out-of-range selector to the smallest note
    first = (r.start_denom > LAST_NOTE) ? LAST_NOTE : r.start_denom;
    stock = '{r.stock_500k, r.stock_200k, r.stock_100k,
              r.stock_50k, r.stock_20k, r.stock_10k};
    for (int k = 0; k < NUM_NOTES; k++) begin
      take = 0;
      if (k >= first) begin
        fit  = left / NOTE_VALUE[k];
        take = (fit < stock[k]) ? fit : stock[k];
        left -= take * NOTE_VALUE[k];
      end
      count[k] = take[CNT_W-1:0];
      total += take;
    end
    p.out_500k    = count[0];
    p.out_200k    = count[1];
    p.out_100k    = count[2];
    p.out_50k     = count[3];
    p.out_20k     = count[4];
    p.out_10k     = count[5];
    p.total_notes = total[TOT_W-1:0];
    p.success     = (left == 0);
    return p;
  endfunction

  function automatic req_t make_request(int unsigned amount, int unsigned start,
                                        int unsigned s500, int unsigned s200,
                                        int unsigned s100, int unsigned s50,
                                        int unsigned s20, int unsigned s10);
    req_t r;
    r.amount      = AMT_W'(amount);
    r.start_denom = SEL_W'(start);
    r.stock_500k  = CNT_W'(s500);
    r.stock_200k  = CNT_W'(s200);
    r.stock_100k  = CNT_W'(s100);
    r.stock_50k   = CNT_W'(s50);
    r.stock_20k   = CNT_W'(s20);
    r.stock_10k   = CNT_W'(s10);
    return r;
  endfunction

  // Append a request to the tail of the pending queue
  task automatic queue_request(req_t r);
    pending_q = {pending_q, r};
  endtask

  // Random withdrawal: mostly whole multiples of the smallest note against
  // realistic stock, the rest odd amounts, raw noise and near-empty stock.
  function automatic req_t random_request();
    int unsigned shape;
    int unsigned cap;
    int unsigned amount;
    int unsigned start;
    shape = $urandom_range(99);
    start = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(5);
    cap   = ($urandom_range(3) == 0) ? 5 : 400;
    if (shape < 55) begin
      amount = ($urandom_range(1) == 0) ? 10000 * $urandom_range(300)
                                        : 10000 * $urandom_range(9999);
      return make_request(amount, start, $urandom_range(cap), $urandom_range(cap),
                          $urandom_range(cap), $urandom_range(cap),
                          $urandom_range(cap), $urandom_range(cap));
    end else if (shape < 75) begin
      return make_request($urandom_range(99999999), start,
                          $urandom_range(400), $urandom_range(400),
                          $urandom_range(400), $urandom_range(400),
                          $urandom_range(400), $urandom_range(400));
    end else if (shape < 90) begin
      return make_request($urandom(), $urandom_range(7), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom());
    end else begin
      return make_request(10000 * $urandom_range(500), start,
                          $urandom_range(2), $urandom_range(2), $urandom_range(2),
                          $urandom_range(2), $urandom_range(2), $urandom_range(2));
    end
  endfunction

  // Idle percentages per phase: sender-light first, receiver-light second,
  // then full speed on both sides.
  function automatic int unsigned sender_idle_pct(int count);
    if (count < item_total / 3) return 11;
    if (count < 2 * item_total / 3) return 54;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct(int count);
    if (count < item_total / 3) return 54;
    if (count < 2 * item_total / 3) return 11;
    return 0;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: record each accepted transaction, then offer the next request
  // or drop valid. Valid and payload hold until the block takes them.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        payout_q = {payout_q, dispense_notes(req)};
        req_sent++;
      end
      if (!req_valid || req_ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct(req_sent)) begin
          req       <= pending_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction and
  // pace rsp_ready, with one long hold-off so the block backs up its input.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (payout_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp);
          mismatches++;
        end else begin
          want = payout_q.pop_front();
          check_field("out_500k", want.out_500k, rsp.out_500k);
          check_field("out_200k", want.out_200k, rsp.out_200k);
          check_field("out_100k", want.out_100k, rsp.out_100k);
          check_field("out_50k", want.out_50k, rsp.out_50k);
          check_field("out_20k", want.out_20k, rsp.out_20k);
          check_field("out_10k", want.out_10k, rsp.out_10k);
          check_field("total_notes", want.total_notes, rsp.total_notes);
          check_field("success", want.success, rsp.success);
        end
        rsp_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (!held_once && rsp_seen == HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= receiver_idle_pct(rsp_seen));
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("limited_stock_note_dispenser regression: fail");
      $finish;
    end
  end

  initial begin
    // Directed part: field extremes, every start selector, the saturating
    // selectors, zero amount, odd amounts and stock running short.
    queue_request(make_request(0, 0, 65535, 65535, 65535, 65535, 65535, 65535));
    queue_request(make_request(99999999, 0, 65535, 65535, 65535, 65535, 65535,
                               65535));
    queue_request(make_request(134217727, 0, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(134217727, 7, 65535, 65535, 65535, 65535, 65535,
                               65535));
    queue_request(make_request(99990000, 0, 65535, 65535, 65535, 65535, 65535,
                               65535));
    queue_request(make_request(880000, 0, 1, 1, 1, 1, 1, 1));
    for (int s = 0; s < 8; s++)
      queue_request(make_request(1880000, s, 65535, 65535, 65535, 65535, 65535,
                                 65535));
    queue_request(make_request(10000, 0, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(5000, 0, 65535, 65535, 65535, 65535, 65535, 65535));
    // Greedy takes the 50000 note and strands 10000 that only 20000s could not pay
    queue_request(make_request(60000, 0, 0, 0, 0, 1, 3, 0));
    queue_request(make_request(99990000, 5, 0, 0, 0, 0, 0, 65535));
    queue_request(make_request(99990000, 6, 65535, 65535, 65535, 65535, 65535, 9998));
    queue_request(make_request(3000000, 1, 3, 2, 4, 1, 0, 65535));
    queue_request(make_request(10000, 5, 0, 0, 0, 0, 0, 1));
    for (int i = 0; i < RANDOM_ITEMS; i++)
      queue_request(random_request());
    item_total = pending_q.size();

    // Hold reset, then release it for good
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Advance until every request is taken and every payout checked
    while (req_sent < item_total || payout_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("limited_stock_note_dispenser regression: pass");
    end else begin
      $display("limited_stock_note_dispenser regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lsnd_pkg.sv
design/lsnd_mul.sv
design/limited_stock_note_dispenser.sv
tb/limited_stock_note_dispenser_tb.sv
